[hdl/mcrs_pkg.sv]
// ----------------------------------------------------------------------------
// mcrs_pkg
// Shared types, constants and the Morton encoding function of the sorter.
// ----------------------------------------------------------------------------
package mcrs_pkg;

  localparam int MAX_ITEMS_DEF  = 64;
  localparam int RADIX_BITS_DEF = 6;
  localparam int KEY_BITS_DEF   = 30;

  localparam int COORD_W = 11;
  localparam int AXIS_W  = 10;
  localparam int CODE_W  = 30;
  localparam int INDEX_W = 16;

  typedef struct packed {
    logic [INDEX_W-1:0] prim_index;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic               final_item;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] sorted_index;
    logic [CODE_W-1:0]  morton_code;
    logic               overflow;
    logic               last_out;
  } out_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [CODE_W-1:0]  code;
  } entry_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CLR,
    S_CNT_RD,
    S_CNT_BK,
    S_CNT_WR,
    S_PFX_RD,
    S_PFX_WR,
    S_SCT_RD,
    S_SCT_BK,
    S_SCT_WR,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic src_rd;
    logic bkt_rd;
    logic cnt_wr;
    logic pfx_rd;
    logic pfx_wr;
    logic sct_wr;
    logic i_clr;
    logic pass_done;
    logic out_ld;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic i_last;
    logic j_last;
    logic pass_last;
    logic out_busy;
  } sts_t;

  // Saturates a coordinate to ten bits.
  function automatic logic [AXIS_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
    clamp_coord = c[AXIS_W] ? {AXIS_W{1'b1}} : c[AXIS_W-1:0];
  endfunction

  // Interleaves the axes, x in the lowest bit of each triple.
  function automatic logic [CODE_W-1:0] morton3(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic [COORD_W-1:0] z);
    logic [AXIS_W-1:0] cx;
    logic [AXIS_W-1:0] cy;
    logic [AXIS_W-1:0] cz;
    logic [CODE_W-1:0] m;
    cx = clamp_coord(x);
    cy = clamp_coord(y);
    cz = clamp_coord(z);
    m  = '0;
    for (int b = 0; b < AXIS_W; b++) begin
      m[3*b]   = cx[b];
      m[3*b+1] = cy[b];
      m[3*b+2] = cz[b];
    end
    morton3 = m;
  endfunction

endpackage

[hdl/mcrs_ctrl.sv]
// ----------------------------------------------------------------------------
// mcrs_ctrl
// Sequencer for load, per-pass clear, count, prefix, scatter and drain.
// ----------------------------------------------------------------------------
module mcrs_ctrl import mcrs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_final,
  input  sts_t   sts,
  output logic   in_ready,
  output cmd_t   cmd,
  output state_t state
);

  state_t state_r;
  state_t state_nxt;

  assign state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:   if (in_valid && in_final) state_nxt = S_CLR;
      S_CLR:    if (sts.j_last) state_nxt = S_CNT_RD;
      S_CNT_RD: state_nxt = S_CNT_BK;
      S_CNT_BK: state_nxt = S_CNT_WR;
      S_CNT_WR: state_nxt = sts.i_last ? S_PFX_RD : S_CNT_RD;
      S_PFX_RD: state_nxt = S_PFX_WR;
      S_PFX_WR: state_nxt = sts.j_last ? S_SCT_RD : S_PFX_RD;
      S_SCT_RD: state_nxt = S_SCT_BK;
      S_SCT_BK: state_nxt = S_SCT_WR;
      S_SCT_WR: begin
        if (sts.i_last) begin
          state_nxt = sts.pass_last ? S_OUT_RD : S_CLR;
        end else begin
          state_nxt = S_SCT_RD;
        end
      end
      S_OUT_RD: if (!sts.out_busy) state_nxt = S_OUT_LD;
      S_OUT_LD: state_nxt = sts.i_last ? S_LOAD : S_OUT_RD;
      default:  state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CLR:    cmd.clr_wr = 1'b1;
      S_CNT_RD: cmd.src_rd = 1'b1;
      S_CNT_BK: cmd.bkt_rd = 1'b1;
      S_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        cmd.i_clr  = sts.i_last;
      end
      S_PFX_RD: cmd.pfx_rd = 1'b1;
      S_PFX_WR: cmd.pfx_wr = 1'b1;
      S_SCT_RD: cmd.src_rd = 1'b1;
      S_SCT_BK: cmd.bkt_rd = 1'b1;
      S_SCT_WR: begin
        cmd.sct_wr    = 1'b1;
        cmd.i_clr     = sts.i_last;
        cmd.pass_done = sts.i_last && !sts.pass_last;
      end
      S_OUT_RD: cmd.src_rd = !sts.out_busy;
      S_OUT_LD: begin
        cmd.out_ld = 1'b1;
        cmd.i_clr  = sts.i_last;
        cmd.finish = sts.i_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[hdl/mcrs_dpath.sv]
// ----------------------------------------------------------------------------
// mcrs_dpath
// Ping-pong item banks, bucket memory, counters and the result register.
// ----------------------------------------------------------------------------
module mcrs_dpath import mcrs_pkg::*; #(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int RADIX_BITS = RADIX_BITS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  input  logic      out_ready,
  output sts_t      sts,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int ADDR_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int BUCKETS    = 1 << RADIX_BITS;
  localparam int NUM_PASSES = (KEY_BITS + RADIX_BITS - 1) / RADIX_BITS;
  localparam int PASS_W     = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;
  localparam int LOW_W      = $clog2(NUM_PASSES * RADIX_BITS + 1);
  localparam int EXT_W      = CODE_W + RADIX_BITS;

  entry_t           bank0 [MAX_ITEMS];
  entry_t           bank1 [MAX_ITEMS];
  logic [CNT_W-1:0] bkt   [BUCKETS];

  logic [CNT_W-1:0]      count_r;
  logic                  ovf_r;
  logic [CNT_W-1:0]      i_r;
  logic [RADIX_BITS-1:0] j_r;
  logic [PASS_W-1:0]     pass_r;
  logic [LOW_W-1:0]      low_r;
  logic                  sel_r;
  logic [CNT_W-1:0]      run_r;
  logic [RADIX_BITS-1:0] d_r;
  entry_t                q0_r;
  entry_t                q1_r;
  logic [CNT_W-1:0]      bkt_q_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  entry_t                src_q;
  entry_t                new_entry;
  logic [EXT_W-1:0]      shifted;
  logic [RADIX_BITS-1:0] digit;
  logic                  store_ok;
  logic [ADDR_W-1:0]     dst_addr;

  assign src_q     = sel_r ? q1_r : q0_r;
  assign shifted   = EXT_W'(src_q.code) >> low_r;
  assign digit     = shifted[RADIX_BITS-1:0];
  assign store_ok  = count_r < CNT_W'(MAX_ITEMS);
  assign dst_addr  = bkt_q_r[ADDR_W-1:0];
  assign new_entry = '{index: in_data.prim_index,
                       code:  morton3(in_data.coord_x, in_data.coord_y, in_data.coord_z)};

  // Bank 0 takes loads and the scatter of odd passes; bank 1 the even ones.
  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      bank0[count_r[ADDR_W-1:0]] <= new_entry;
    end else if (cmd.sct_wr && sel_r) begin
      bank0[dst_addr] <= src_q;
    end
    if (cmd.src_rd) begin
      q0_r <= bank0[i_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sct_wr && !sel_r) begin
      bank1[dst_addr] <= src_q;
    end
    if (cmd.src_rd) begin
      q1_r <= bank1[i_r[ADDR_W-1:0]];
    end
  end

  // Bucket memory: clear, increment, prefix rewrite and scatter bump.
  always_ff @(posedge clk) begin
    priority if (cmd.clr_wr) begin
      bkt[j_r] <= '0;
    end else if (cmd.pfx_wr) begin
      bkt[j_r] <= run_r;
    end else if (cmd.cnt_wr || cmd.sct_wr) begin
      bkt[d_r] <= bkt_q_r + CNT_W'(1);
    end
    if (cmd.bkt_rd) begin
      bkt_q_r <= bkt[digit];
    end else if (cmd.pfx_rd) begin
      bkt_q_r <= bkt[j_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bkt_rd) begin
      d_r <= digit;
    end
    if (cmd.clr_wr) begin
      run_r <= '0;
    end else if (cmd.pfx_wr) begin
      run_r <= run_r + bkt_q_r;
    end
    if (cmd.out_ld) begin
      out_r <= '{sorted_index: src_q.index, morton_code: src_q.code,
                 overflow: ovf_r, last_out: sts.i_last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      pass_r      <= '0;
      low_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (store_ok) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.i_clr) begin
        i_r <= '0;
      end else if (cmd.cnt_wr || cmd.sct_wr || cmd.out_ld) begin
        i_r <= i_r + CNT_W'(1);
      end
      if (cmd.clr_wr || cmd.pfx_wr) begin
        j_r <= j_r + RADIX_BITS'(1);
      end
      if (cmd.sct_wr && cmd.i_clr) begin
        sel_r <= !sel_r;
      end
      if (cmd.pass_done) begin
        pass_r <= pass_r + PASS_W'(1);
        low_r  <= low_r + LOW_W'(RADIX_BITS);
      end
      if (cmd.finish) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        pass_r  <= '0;
        low_r   <= '0;
        sel_r   <= 1'b0;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.i_last    = (i_r == count_r - CNT_W'(1));
  assign sts.j_last    = (j_r == {RADIX_BITS{1'b1}});
  assign sts.pass_last = (pass_r == PASS_W'(NUM_PASSES - 1));
  assign sts.out_busy  = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hdl/morton_code_radix_sorter_core.sv]
// ----------------------------------------------------------------------------
// morton_code_radix_sorter_core
// Morton encoder and stable LSD radix sorter for one set of primitives.
// ----------------------------------------------------------------------------
// Items are taken one per cycle while loading and stored as (index, code)
// pairs until the item marked final; extra items beyond MAX_ITEMS are dropped
// and flagged. The sort then runs one pass per RADIX_BITS digit, each pass
// clearing every bucket, counting each item (source read, bucket read,
// increment), forming the prefix of each bucket (read, write) and scattering
// each item (source read, bucket read, write), since every step goes through
// the single-port bucket memory. Results then leave one at a time, each one
// loaded only once the previous one has been taken. No new request is taken
// until the last result has been loaded for delivery.
module morton_code_radix_sorter_core import mcrs_pkg::*; #(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int RADIX_BITS = RADIX_BITS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  mcrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_final (in_data.final_item),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd),
    .state    (state)
  );

  mcrs_dpath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .RADIX_BITS (RADIX_BITS),
    .KEY_BITS   (KEY_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Only one write source may drive the datapath memories in a cycle.
  a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.clr_wr, cmd.cnt_wr, cmd.pfx_wr, cmd.sct_wr, cmd.out_ld}))
    else $error("datapath write commands overlap");

  // A pending result must never be overwritten.
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> !sts.out_busy)
    else $error("result register overwritten");

  // The run ends only when its last result is loaded for delivery.
  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid && out_data.last_out && state == S_LOAD)
    else $error("run finished without last result");

endmodule

[sim/morton_sort_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morton_sort_checker
// Watches both channels of the sorter, predicts each sorted run and compares.
// ----------------------------------------------------------------------------
module morton_sort_checker import mcrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_count
);

  localparam int CAPACITY = MAX_ITEMS_DEF;

  logic [CODE_W-1:0]  set_code[$];
  logic [INDEX_W-1:0] set_index[$];
  logic               set_overflow;
  out_item_t          sorted_results[$];

  function automatic logic [CODE_W-1:0] encode_axes(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y,
                                                    input logic [COORD_W-1:0] z);
    logic [9:0] cx;
    logic [9:0] cy;
    logic [9:0] cz;
    logic [CODE_W-1:0] m;
    cx = (x > 11'd1023) ? 10'h3ff : x[9:0];
    cy = (y > 11'd1023) ? 10'h3ff : y[9:0];
    cz = (z > 11'd1023) ? 10'h3ff : z[9:0];
    m = '0;
    for (int b = 0; b < 10; b++) begin
      m[3*b+2 -: 3] = {cz[b], cy[b], cx[b]};
    end
    return m;
  endfunction

  // A stable insertion sort gives the same order as the stable radix sort.
  task automatic emit_sorted_set();
    int n;
    logic [CODE_W-1:0] kc;
    logic [INDEX_W-1:0] ki;
    int j;
    out_item_t r;
    n = set_code.size();
    for (int i = 1; i < n; i++) begin
      kc = set_code[i];
      ki = set_index[i];
      j = i - 1;
      while (j >= 0 && set_code[j] > kc) begin
        set_code[j+1] = set_code[j];
        set_index[j+1] = set_index[j];
        j--;
      end
      set_code[j+1] = kc;
      set_index[j+1] = ki;
    end
    for (int k = 0; k < n; k++) begin
      r.sorted_index = set_index[k];
      r.morton_code = set_code[k];
      r.overflow = set_overflow;
      r.last_out = (k == n - 1);
      sorted_results = {sorted_results, r};
    end
    set_code.delete();
    set_index.delete();
    set_overflow = 1'b0;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    set_overflow = 1'b0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && in_valid && in_ready) begin
      if (set_code.size() < CAPACITY) begin
        set_code = {set_code,
                    encode_axes(in_data.coord_x, in_data.coord_y, in_data.coord_z)};
        set_index = {set_index, in_data.prim_index};
      end else begin
        set_overflow = 1'b1;
      end
      if (in_data.final_item) begin
        emit_sorted_set();
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (sorted_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        fail_count++;
      end else begin
        want = sorted_results.pop_front();
        if (want.sorted_index !== out_data.sorted_index) begin
          $display("%0t: sorted_index expected %h actual %h", $time,
                   want.sorted_index, out_data.sorted_index);
          fail_count++;
        end
        if (want.morton_code !== out_data.morton_code) begin
          $display("%0t: morton_code expected %h actual %h", $time,
                   want.morton_code, out_data.morton_code);
          fail_count++;
        end
        if (want.overflow !== out_data.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time,
                   want.overflow, out_data.overflow);
          fail_count++;
        end
        if (want.last_out !== out_data.last_out) begin
          $display("%0t: last_out expected %b actual %b", $time,
                   want.last_out, out_data.last_out);
          fail_count++;
        end
      end
    end
    pending_count = sorted_results.size();
  end

endmodule

[sim/morton_code_radix_sorter_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morton_code_radix_sorter_core_test
// Drives sets of primitives with random pacing and reports the verdict.
// ----------------------------------------------------------------------------
module morton_code_radix_sorter_core_test;
  import mcrs_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending_count;
  int        cycle_count;
  int        sent_count;

  morton_code_radix_sorter_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  morton_sort_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The receiver alternates between free stretches and random stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if ((cycle_count / 200) % 3 == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 11'd0;
      1: return 11'd1023;
      2: return 11'd1024;
      3: return COORD_W'($urandom_range(1025, 2047));
      default: return COORD_W'($urandom_range(0, 1024));
    endcase
  endfunction

  // Holds one request until the block takes it.
  task automatic send_item(input in_item_t item);
    in_valid = 1'b1;
    in_data = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic send_set(input int n, input bit pace);
    in_item_t item;
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (pace && burst == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
        burst = $urandom_range(1, 12);
      end
      item.prim_index = 16'($urandom);
      item.coord_x = pick_coord();
      item.coord_y = pick_coord();
      item.coord_z = pick_coord();
      item.final_item = (i == n - 1);
      send_item(item);
      burst--;
    end
    in_valid = 1'b0;
  endtask

  initial begin
    in_item_t item;
    cycle_count = 0;
    sent_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: extremes of every field, equal codes for stability, a lone item.
    item = '{16'hffff, 11'd1024, 11'd1024, 11'd1024, 1'b0};
    send_item(item);
    item = '{16'h0000, 11'd0, 11'd0, 11'd0, 1'b0};
    send_item(item);
    item = '{16'h1234, 11'd2047, 11'd1023, 11'd1025, 1'b0};
    send_item(item);
    item = '{16'h5555, 11'd0, 11'd0, 11'd0, 1'b0};
    send_item(item);
    item = '{16'haaaa, 11'd1, 11'd2, 11'd4, 1'b1};
    send_item(item);
    in_valid = 1'b0;
    item = '{16'h0042, 11'd512, 11'd256, 11'd128, 1'b1};
    send_item(item);
    in_valid = 1'b0;

    // Full store plus dropped items; the final one is also past capacity.
    send_set(70, 1'b0);

    // Wait until every result has come before resuming.
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    while (sent_count < 420) begin
      case ($urandom_range(0, 7))
        0: send_set(1, 1'b1);
        1: send_set($urandom_range(60, 66), 1'b1);
        default: send_set($urandom_range(2, 24), 1'b1);
      endcase
    end

    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/mcrs_pkg.sv
hdl/mcrs_ctrl.sv
hdl/mcrs_dpath.sv
hdl/morton_code_radix_sorter_core.sv
sim/morton_sort_checker.sv
sim/morton_code_radix_sorter_core_test.sv
